// ===== hdl/pll_divider_search_macros.svh =====
// ---------------------------------------------------------------------------
// pll divider search assertion macros
// shared concurrent assertion forms for the divider search
// ---------------------------------------------------------------------------
`ifndef PLL_DIVIDER_SEARCH_MACROS_SVH
`define PLL_DIVIDER_SEARCH_MACROS_SVH

// a property that must hold at every clock edge outside reset
`define PDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pds assertion failed");

// an implication whose consequence is checked in the cycle after the antecedent
`define PDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pds assertion failed");

`endif

// ===== hdl/pds_pkg.sv =====
// ---------------------------------------------------------------------------
// pll divider search package
// shared widths, constants and status codes
// ---------------------------------------------------------------------------
package pds_pkg;

  localparam int unsigned NrLimitDef = 200;
  localparam int unsigned OdLimitDef = 2048;

  localparam logic [31:0] ResetLimitHz = 32'd2200000000;
  localparam logic [20:0] NfMax        = 21'h1FFFFF;
  localparam logic [9:0]  Permille     = 10'd1000;

  localparam logic [1:0] StFound   = 2'd0;
  localparam logic [1:0] StZeroIn  = 2'd1;
  localparam logic [1:0] StNoSoln  = 2'd2;

  localparam logic CfgMaxVco = 1'b0;
  localparam logic CfgMaxOut = 1'b1;

endpackage

// ===== hdl/pds_divider.sv =====
// ---------------------------------------------------------------------------
// pll divider search bit-serial divider
// restoring division of a 64-bit dividend by a 64-bit divisor, one quotient
// bit per cycle
// ---------------------------------------------------------------------------
module pds_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] quot_q, quot_d;
  logic [63:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;
  logic [64:0] shifted;

  assign shifted = {rem_q, quot_q[63]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
      end else begin
        rem_d = shifted[63:0];
      end
      quot_d = {quot_q[62:0], ~trial[64]};
      cnt_d  = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hdl/pll_divider_search.sv =====
// ---------------------------------------------------------------------------
// pll divider search
// searches integer reference, output and feedback dividers for a request
// ---------------------------------------------------------------------------
// a transaction on the input channel (in_valid_i / in_ready_o) carries the
// reference and requested rates; one result transaction follows on the
// output channel (out_valid_o / out_ready_i).
// the search walks nr from 1 to NR_LIMIT-1 and od from 1 to the od bound.
// all divisions share one bit-serial divider. the od bound takes one
// division at the start. a full candidate takes four divisions; a
// candidate with nf too wide ends after the first division, one over the
// output limit after the second and one over the vco limit after the
// third. the worst case walks every candidate; typical requests end far
// sooner at the first exact hit. the result of a zero input is offered
// in the cycle after acceptance.
// one request is in work at a time; in_ready_o is low from acceptance until
// the result is taken. a stalled receiver holds the result in the output
// register. reset restores both limit registers to 2.2 GHz and empties the
// block. limits are written through cfg_we_i / cfg_idx_i / cfg_data_i.
// ---------------------------------------------------------------------------
`include "pll_divider_search_macros.svh"

module pll_divider_search #(
  parameter int unsigned NR_LIMIT = pds_pkg::NrLimitDef,
  parameter int unsigned OD_LIMIT = pds_pkg::OdLimitDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] ref_freq_hz_i,
  input  logic [31:0] req_freq_hz_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  ref_div_o,
  output logic [11:0] out_div_o,
  output logic [20:0] fb_mult_o,
  output logic [31:0] achieved_hz_o,
  output logic [9:0]  error_permille_o
);

  localparam int NrW = $clog2(NR_LIMIT);
  localparam int OdW = $clog2(OD_LIMIT + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ODB  = 4'd1;
  localparam logic [3:0] S_NF   = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_FO   = 4'd4;
  localparam logic [3:0] S_FV   = 4'd5;
  localparam logic [3:0] S_SC   = 4'd6;
  localparam logic [3:0] S_EVAL = 4'd7;
  localparam logic [3:0] S_NEXT = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;
  localparam logic [3:0] S_WAIT = 4'd11;

  logic [3:0]  state_q, state_d;
  logic [31:0] max_vco_q, max_out_q;
  logic [31:0] ref_q, req_q;
  logic [OdW-1:0] odmax_q;
  logic [NrW-1:0] nr_q;
  logic [OdW-1:0] od_q;
  logic [NrW+OdW-1:0] div_q;
  logic [20:0] nf_q;
  logic [31:0] fout_q;
  logic        have_q, exact_q;
  logic [NrW-1:0] bnr_q;
  logic [OdW-1:0] bod_q;
  logic [20:0] bnf_q;
  logic [31:0] bhz_q;
  logic [9:0]  berr_q;
  logic [1:0]  st_q;
  logic [9:0]  err;
  logic [52:0] prod_q;

  logic        dv_start;
  logic [63:0] dv_num, dv_den;
  logic        dv_done;
  logic [63:0] dv_quot;
  logic        wait_q;

  logic [OdW-1:0] od_n;
  logic [NrW-1:0] nr_n;
  logic           first_q;
  logic           walk_end;

  pds_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_num),
    .divisor_i  (dv_den),
    .done_o     (dv_done),
    .quot_o     (dv_quot)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    if (dv_quot[9:0] >= pds_pkg::Permille) begin
      err = dv_quot[9:0] - pds_pkg::Permille;
    end else begin
      err = pds_pkg::Permille - dv_quot[9:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vco_q <= pds_pkg::ResetLimitHz;
      max_out_q <= pds_pkg::ResetLimitHz;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pds_pkg::CfgMaxVco) begin
        max_vco_q <= cfg_data_i;
      end else begin
        max_out_q <= cfg_data_i;
      end
    end
  end

  // candidate walk: S_NEXT advances (nr, od)
  always_comb begin
    od_n     = od_q;
    nr_n     = nr_q;
    walk_end = 1'b0;
    if (first_q) begin
      od_n = {{(OdW-1){1'b0}}, 1'b1};
      nr_n = {{(NrW-1){1'b0}}, 1'b1};
      walk_end = (odmax_q == '0);
    end else if (od_q >= odmax_q) begin
      od_n = {{(OdW-1){1'b0}}, 1'b1};
      nr_n = nr_q + {{(NrW-1){1'b0}}, 1'b1};
      walk_end = ({1'b0, nr_n} >= (NrW+1)'(NR_LIMIT)) || (nr_q == '1);
    end else begin
      od_n = od_q + {{(OdW-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    state_d  = state_q;
    dv_start = 1'b0;
    dv_num   = '0;
    dv_den   = 64'd1;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (ref_freq_hz_i == '0 || req_freq_hz_i == '0) begin
            state_d = S_OUT;
          end else begin
            state_d  = S_ODB;
            dv_start = 1'b1;
            dv_num   = {32'd0, max_vco_q};
            dv_den   = {32'd0, req_freq_hz_i};
          end
        end
      end
      S_ODB: begin
        if (dv_done) begin
          state_d = S_NEXT;
        end
      end
      S_NF: begin
        if (dv_done) begin
          if (dv_quot > {43'd0, pds_pkg::NfMax}) begin
            state_d = S_NEXT;
          end else begin
            state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (wait_q) begin
          state_d  = S_FO;
          dv_start = 1'b1;
          dv_num   = {11'd0, prod_q};
          dv_den   = {{(64-NrW-OdW){1'b0}}, div_q};
        end
      end
      S_FO: begin
        if (dv_done) begin
          if (dv_quot > {32'd0, max_out_q}) begin
            state_d = S_NEXT;
          end else begin
            state_d  = S_FV;
            dv_start = 1'b1;
            dv_num   = {11'd0, prod_q};
            dv_den   = {{(64-NrW){1'b0}}, nr_q};
          end
        end
      end
      S_FV: begin
        if (dv_done) begin
          if (dv_quot > {32'd0, max_vco_q}) begin
            state_d = S_NEXT;
          end else begin
            state_d  = S_SC;
            dv_start = 1'b1;
            dv_num   = {22'd0, fout_q, 10'd0} - {29'd0, fout_q, 3'd0}
                       - {28'd0, fout_q, 4'd0};
            dv_den   = {32'd0, req_q};
          end
        end
      end
      S_SC: begin
        if (dv_done) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_NEXT;
      end
      S_NEXT: begin
        if (exact_q || walk_end) begin
          state_d = S_DONE;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d  = S_NF;
        dv_start = 1'b1;
        dv_num   = {11'd0, 53'(req_q) * 53'(div_q)};
        dv_den   = {32'd0, ref_q};
      end
      S_DONE: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      have_q  <= 1'b0;
      exact_q <= 1'b0;
      first_q <= 1'b0;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= (state_q == S_CHK) && !wait_q;
      if (state_q == S_IDLE && in_valid_i) begin
        have_q  <= 1'b0;
        exact_q <= 1'b0;
        first_q <= 1'b1;
      end
      if (state_q == S_NEXT) begin
        first_q <= 1'b0;
      end
      if (state_q == S_EVAL && (!have_q || err < berr_q)) begin
        have_q <= 1'b1;
      end
      if (state_q == S_EVAL && err == '0) begin
        exact_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      ref_q <= ref_freq_hz_i;
      req_q <= req_freq_hz_i;
      st_q  <= pds_pkg::StZeroIn;
    end
    if (state_q == S_ODB && dv_done) begin
      if (dv_quot > 64'(OD_LIMIT)) begin
        odmax_q <= OdW'(OD_LIMIT);
      end else begin
        odmax_q <= dv_quot[OdW-1:0];
      end
    end
    if (state_q == S_NEXT && state_d == S_WAIT) begin
      nr_q   <= nr_n;
      od_q   <= od_n;
      div_q  <= (NrW+OdW)'(nr_n) * (NrW+OdW)'(od_n);
    end
    if (state_q == S_NF && dv_done) begin
      nf_q <= dv_quot[20:0];
    end
    if (state_q == S_CHK && !wait_q) begin
      prod_q <= 53'(ref_q) * 53'(nf_q);
    end
    if (state_q == S_FO && dv_done) begin
      fout_q <= dv_quot[31:0];
    end
    if (state_q == S_EVAL && (!have_q || err < berr_q)) begin
      bnr_q  <= nr_q;
      bod_q  <= od_q;
      bnf_q  <= nf_q;
      bhz_q  <= fout_q;
      berr_q <= err;
    end
    if (state_q == S_DONE) begin
      st_q <= have_q ? pds_pkg::StFound : pds_pkg::StNoSoln;
    end
  end

  assign status_o         = st_q;
  assign ref_div_o        = (st_q == pds_pkg::StFound) ? 8'(bnr_q) : '0;
  assign out_div_o        = (st_q == pds_pkg::StFound) ? 12'(bod_q) : '0;
  assign fb_mult_o        = (st_q == pds_pkg::StFound) ? bnf_q : '0;
  assign achieved_hz_o    = (st_q == pds_pkg::StFound) ? bhz_q : '0;
  assign error_permille_o = (st_q == pds_pkg::StFound) ? berr_q : '0;

  `PDS_ASSERT(a_hs_excl, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  `PDS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `PDS_ASSERT_NEXT(a_done_out, clk_i, rst_ni, state_q == S_DONE, out_valid_o)

endmodule
